// ===== rtl/tsst_pkg.sv =====
package tsst_pkg;

   localparam int SPEED_BITS = 24;
   localparam int NUM_W      = 27;
   localparam int DEN_W      = 32;
   localparam int MPH_W      = 16;
   localparam int PROD_W     = NUM_W + MPH_W;
   localparam int CNT_W      = $clog2(NUM_W);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [8:0]        HOUR_FACTOR = 9'd360;
   localparam logic [MPH_W-1:0]  MPH_FACTOR  = 16'd40722;
   localparam logic [32:0]       SPEED_MAX   = (33'd1 << SPEED_BITS) - 33'd1;

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_SENSA    = 3'd1;
   localparam logic [2:0] ST_SENSB    = 3'd2;
   localparam logic [2:0] ST_UPDATED  = 3'd3;
   localparam logic [2:0] ST_ACTIVE   = 3'd4;
   localparam logic [2:0] ST_CLEARING = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_SPACING     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_METRIC      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_LOW     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_HIGH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_TMO  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_TMO   = 3'd6;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        sensors_ready;
      logic [7:0]  range_a;
      logic [7:0]  range_b;
      logic        speed_taken;
   } req_type;

   typedef struct packed {
      logic                  trigger_sensors;
      logic [2:0]            machine_state;
      logic [SPEED_BITS-1:0] speed_hundredths;
      logic                  speed_new;
      logic                  waiting_led;
      logic                  detect_a;
      logic                  detect_b;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic prep;
      logic div_step;
      logic mul;
      logic fin;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/tsst_ctrl.sv =====
module tsst_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tsst_pkg::sts_type sts,
   output tsst_pkg::cmd_type cmd
);
   import tsst_pkg::*;

   localparam logic [2:0] C_IDLE = 3'd0;
   localparam logic [2:0] C_EVAL = 3'd1;
   localparam logic [2:0] C_PREP = 3'd2;
   localparam logic [2:0] C_DIV  = 3'd3;
   localparam logic [2:0] C_MUL  = 3'd4;
   localparam logic [2:0] C_FIN  = 3'd5;
   localparam logic [2:0] C_LOAD = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_stall = (state_ff != C_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         C_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = C_EVAL;
            end
         end
         C_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.need_div ? C_PREP : C_LOAD;
         end
         C_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = C_DIV;
         end
         C_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = C_MUL;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         C_MUL: begin
            cmd.mul  = 1'b1;
            state_in = C_FIN;
         end
         C_FIN: begin
            cmd.fin  = 1'b1;
            state_in = C_LOAD;
         end
         C_LOAD: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/tsst_dp.sv =====
module tsst_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  tsst_pkg::cmd_type                  cmd,
   output tsst_pkg::sts_type                  sts,
   input  tsst_pkg::req_type                  req_data,
   input  logic                               csr_wr,
   input  logic [tsst_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tsst_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tsst_pkg::rsp_type                  rsp_data
);
   import tsst_pkg::*;

   // configuration
   logic [9:0]  spacing_ff;
   logic [7:0]  scale_ff;
   logic        metric_ff;
   logic [7:0]  win_low_ff;
   logic [7:0]  win_high_ff;
   logic [15:0] second_tmo_ff;
   logic [15:0] clear_tmo_ff;
   logic [17:0] pair_ff;

   // trap state
   logic                  triggered_ff, triggered_in;
   logic                  det_a_ff, det_a_in;
   logic                  det_b_ff, det_b_in;
   logic [2:0]            fsm_ff, fsm_in;
   logic [31:0]           mark_ff, mark_in;
   logic [SPEED_BITS-1:0] speed_ff;
   logic                  updated_ff, updated_in;
   logic                  trig_ff, trig_in;
   logic                  clr_speed;
   logic                  need_div;

   // tick and arithmetic
   req_type               in_ff;
   logic [31:0]           elapsed;
   logic [DEN_W-1:0]      den_ff;
   logic                  zero_ff;
   logic [DEN_W-1:0]      rem_ff;
   logic [NUM_W-1:0]      quo_ff;
   logic [DEN_W:0]        rem_shift;
   logic [DEN_W:0]        rem_diff;
   logic [PROD_W-1:0]     prod_ff;
   logic [NUM_W-1:0]      q_sel;
   logic [32:0]           q_ext;
   logic [SPEED_BITS-1:0] speed_res;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff    <= 10'd127;
         scale_ff      <= 8'd87;
         metric_ff     <= 1'b0;
         win_low_ff    <= 8'd0;
         win_high_ff   <= 8'd255;
         second_tmo_ff <= 16'd45455;
         clear_tmo_ff  <= 16'd1500;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_SPACING:    spacing_ff    <= csr_data[9:0];
            CSR_SCALE:      scale_ff      <= csr_data[7:0];
            CSR_METRIC:     metric_ff     <= csr_data[0];
            CSR_WIN_LOW:    win_low_ff    <= csr_data[7:0];
            CSR_WIN_HIGH:   win_high_ff   <= csr_data[7:0];
            CSR_SECOND_TMO: second_tmo_ff <= csr_data;
            CSR_CLEAR_TMO:  clear_tmo_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= 18'(spacing_ff) * 18'(scale_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_ff <= req_data;
      end
   end

   assign elapsed = in_ff.now_ms - mark_ff;

   // one tick of the trap
   always_comb begin
      triggered_in = triggered_ff;
      det_a_in     = det_a_ff;
      det_b_in     = det_b_ff;
      fsm_in       = fsm_ff;
      mark_in      = mark_ff;
      trig_in      = 1'b0;
      clr_speed    = 1'b0;
      need_div     = 1'b0;
      updated_in   = in_ff.speed_taken ? 1'b0 : updated_ff;

      if (!triggered_ff) begin
         trig_in      = 1'b1;
         triggered_in = 1'b1;
      end else if (in_ff.sensors_ready) begin
         triggered_in = 1'b0;
         det_a_in = (in_ff.range_a >= win_low_ff) && (in_ff.range_a <= win_high_ff);
         det_b_in = (in_ff.range_b >= win_low_ff) && (in_ff.range_b <= win_high_ff);
      end

      case (fsm_ff)
         ST_SENSA, ST_SENSB: begin
            if ((fsm_ff == ST_SENSA) ? det_b_in : det_a_in) begin
               need_div   = 1'b1;
               updated_in = 1'b1;
               mark_in    = in_ff.now_ms;
               fsm_in     = ST_UPDATED;
            end else if (elapsed > {16'd0, second_tmo_ff}) begin
               clr_speed = 1'b1;
               fsm_in    = ST_ACTIVE;
            end
         end
         ST_UPDATED: begin
            if (!updated_in) begin
               fsm_in = ST_ACTIVE;
            end
         end
         ST_ACTIVE: begin
            if (!det_a_in && !det_b_in) begin
               mark_in = in_ff.now_ms;
               fsm_in  = ST_CLEARING;
            end
         end
         ST_CLEARING: begin
            if (det_a_in || det_b_in) begin
               fsm_in = ST_ACTIVE;
            end else if (elapsed > {16'd0, clear_tmo_ff}) begin
               fsm_in = ST_CLEAR;
            end
         end
         default: begin
            if (det_a_in && det_b_in) begin
               fsm_in = ST_CLEARING;
            end else if (det_a_in) begin
               mark_in = in_ff.now_ms;
               fsm_in  = ST_SENSA;
            end else if (det_b_in) begin
               mark_in = in_ff.now_ms;
               fsm_in  = ST_SENSB;
            end else begin
               fsm_in = ST_CLEAR;
            end
         end
      endcase
   end

   assign sts.need_div = need_div;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         triggered_ff <= 1'b0;
         det_a_ff     <= 1'b0;
         det_b_ff     <= 1'b0;
         fsm_ff       <= ST_CLEAR;
         mark_ff      <= '0;
         updated_ff   <= 1'b0;
         speed_ff     <= '0;
         trig_ff      <= 1'b0;
      end else if (cmd.eval) begin
         triggered_ff <= triggered_in;
         det_a_ff     <= det_a_in;
         det_b_ff     <= det_b_in;
         fsm_ff       <= fsm_in;
         mark_ff      <= mark_in;
         updated_ff   <= updated_in;
         trig_ff      <= trig_in;
         if (clr_speed) begin
            speed_ff <= '0;
         end
      end else if (cmd.fin) begin
         speed_ff <= speed_res;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         den_ff  <= elapsed;
         zero_ff <= (elapsed == 32'd0);
      end
   end

   // restoring divider, one quotient bit per step
   assign rem_shift = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         rem_ff <= '0;
         quo_ff <= NUM_W'(pair_ff) * NUM_W'(HOUR_FACTOR);
      end else if (cmd.div_step) begin
         if (!rem_diff[DEN_W]) begin
            rem_ff <= rem_diff[DEN_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[DEN_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= PROD_W'(quo_ff) * PROD_W'(MPH_FACTOR);
      end
   end

   assign q_sel     = metric_ff ? quo_ff : prod_ff[PROD_W-1:MPH_W];
   assign q_ext     = 33'(q_sel);
   assign speed_res = (zero_ff || (q_ext > SPEED_MAX)) ? SPEED_MAX[SPEED_BITS-1:0]
                                                      : q_ext[SPEED_BITS-1:0];

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff.trigger_sensors  <= trig_ff;
         rsp_ff.machine_state    <= fsm_ff;
         rsp_ff.speed_hundredths <= speed_ff;
         rsp_ff.speed_new        <= updated_ff;
         rsp_ff.waiting_led      <= (fsm_ff == ST_SENSA) || (fsm_ff == ST_SENSB);
         rsp_ff.detect_a         <= det_a_ff;
         rsp_ff.detect_b         <= det_b_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/two_sensor_speed_trap_top.sv =====
// a tick is captured, evaluated and loaded once the output is free; a tick
//    that measures a speed first runs the 27-step restoring divider for the
//    speed quotient; no new tick is taken until the result has been loaded
// reset: synchronous, active high; clears trap state, speed and flags and
//    loads the registers with their defaults; no clearing pass
module two_sensor_speed_trap_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tsst_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tsst_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tsst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tsst_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tsst_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   tsst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tsst_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_wr    (csr_wr),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
